// ===== rtl/ceb_pkg.sv =====
// ----------------------------------------------------------------------------
// ceb_pkg
// Types and widths shared by the two-circle elastic bounce pipeline.
// ----------------------------------------------------------------------------
package ceb_pkg;

  localparam int VW    = 24;          // velocity / position width
  localparam int MW    = 16;          // radius / mass width
  localparam int DXW   = VW + 1;      // centre and velocity differences
  localparam int SQW   = 2 * DXW;     // squared differences, squared distance
  localparam int RSW   = MW + 1;      // radius sum, mass sum, doubled mass
  localparam int RRW   = 2 * RSW;     // squared radius sum
  localparam int DOTW  = SQW + 1;     // relative velocity dot centre line
  localparam int ADOTW = SQW;         // magnitude of the dot product
  localparam int ADW   = VW;          // magnitude of a centre difference
  localparam int HW    = 25;          // operand split for the multipliers
  localparam int LPW   = HW + ADW;    // dot x component partial product
  localparam int PW    = ADOTW + ADW; // dot x component
  localparam int DNPW  = RSW + HW;    // mass sum x distance partial product
  localparam int DENW  = RSW + SQW;   // mass sum x squared distance
  localparam int PPW   = RSW + HW;    // weight x component partial product
  localparam int NUMW  = PPW + 2 * HW;
  localparam int NW    = NUMW + 1;    // dividend: 2*num + den
  localparam int DW    = DENW + 1;    // divisor: 2*den
  localparam int QW    = 27;          // rounded quotient stays below 2^26
  localparam int RW    = DW + QW;     // divider partial remainder
  localparam int AW    = QW + 1;      // signed correction term
  localparam int SW    = QW + 4;      // unsaturated result velocity
  localparam int FRONT_STAGES = 8;
  localparam int LAT   = FRONT_STAGES + QW + 1;

  localparam logic signed [VW-1:0] V_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] V_MIN = {1'b1, {(VW-1){1'b0}}};

  typedef struct packed {
    logic signed [VW-1:0] first_x;
    logic signed [VW-1:0] first_y;
    logic signed [VW-1:0] second_x;
    logic signed [VW-1:0] second_y;
    logic signed [VW-1:0] first_vx;
    logic signed [VW-1:0] first_vy;
    logic signed [VW-1:0] second_vx;
    logic signed [VW-1:0] second_vy;
    logic [MW-1:0]        first_radius;
    logic [MW-1:0]        second_radius;
    logic [MW-1:0]        first_mass;
    logic [MW-1:0]        second_mass;
  } ceb_in_t;

  typedef struct packed {
    logic                 touching;
    logic                 bounced;
    logic signed [VW-1:0] new_first_vx;
    logic signed [VW-1:0] new_first_vy;
    logic signed [VW-1:0] new_second_vx;
    logic signed [VW-1:0] new_second_vy;
    logic                 clipped;
  } ceb_out_t;

  // Per-transaction side data that rides along with the arithmetic
  typedef struct packed {
    logic signed [VW-1:0] v1x;
    logic signed [VW-1:0] v1y;
    logic signed [VW-1:0] v2x;
    logic signed [VW-1:0] v2y;
    logic                 touch;
    logic                 bounce;
    logic                 neg_x;
    logic                 neg_y;
  } ceb_side_t;

endpackage

// ===== rtl/ceb_front.sv =====
// ----------------------------------------------------------------------------
// ceb_front
// Eight register stages: differences, products, overlap test, dot product,
// then the four correction dividends and the shared divisor.
// ----------------------------------------------------------------------------
module ceb_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  ceb_pkg::ceb_in_t                  in_i,
  output logic                              valid_o,
  output ceb_pkg::ceb_side_t                side_o,
  output logic [3:0][ceb_pkg::NW-1:0]       num_o,
  output logic [ceb_pkg::DW-1:0]            den_o
);
  import ceb_pkg::*;

  function automatic logic [2:0][PPW-1:0] mul3(input logic [PW-1:0] p,
                                               input logic [RSW-1:0] w);
    logic [2:0][PPW-1:0] r;
    r[0] = p[HW-1:0] * w;
    r[1] = p[2*HW-1:HW] * w;
    r[2] = p[PW-1:2*HW] * w;
    return r;
  endfunction

  logic [FRONT_STAGES-1:0] vld_q;

  // stage 1
  logic signed [DXW-1:0] s1_dx_q, s1_dy_q, s1_dvx_q, s1_dvy_q;
  logic [RSW-1:0]        s1_rs_q, s1_msum_q;
  logic [MW-1:0]         s1_m1_q, s1_m2_q;
  logic                  s1_mov_q;
  ceb_side_t             s1_side_q;
  // stage 2
  logic signed [SQW-1:0] s2_dxx_q, s2_dyy_q, s2_px_q, s2_py_q;
  logic [RRW-1:0]        s2_rr_q;
  logic [ADW-1:0]        s2_adx_q, s2_ady_q;
  logic                  s2_nx_q, s2_ny_q, s2_mov_q;
  logic [RSW-1:0]        s2_msum_q;
  logic [MW-1:0]         s2_m1_q, s2_m2_q;
  ceb_side_t             s2_side_q;
  // stage 3
  logic [SQW-1:0]        d2_3;
  logic signed [DOTW-1:0] dot_3;
  logic                  touch_3;
  logic [SQW-1:0]        s3_d2_q;
  logic [ADOTW-1:0]      s3_adot_q;
  logic [ADW-1:0]        s3_adx_q, s3_ady_q;
  logic [RSW-1:0]        s3_msum_q;
  logic [MW-1:0]         s3_m1_q, s3_m2_q;
  ceb_side_t             s3_side_q;
  // stage 4
  logic [LPW-1:0]        s4_pxl_q, s4_pxh_q, s4_pyl_q, s4_pyh_q;
  logic [DNPW-1:0]       s4_dnl_q, s4_dnh_q;
  logic [MW-1:0]         s4_m1_q, s4_m2_q;
  ceb_side_t             s4_side_q;
  // stage 5
  logic [PW-1:0]         s5_px_q, s5_py_q;
  logic [DENW-1:0]       s5_den_q;
  logic [RSW-1:0]        s5_w1_q, s5_w2_q;
  ceb_side_t             s5_side_q;
  // stage 6
  logic [3:0][2:0][PPW-1:0] s6_pp_q;
  logic [DENW-1:0]       s6_den_q;
  ceb_side_t             s6_side_q;
  // stage 7
  logic [3:0][NUMW-1:0]  s7_num_q;
  logic [DENW-1:0]       s7_den_q;
  ceb_side_t             s7_side_q;
  // stage 8
  logic [3:0][NW-1:0]    s8_n_q;
  logic [DW-1:0]         s8_d_q;
  ceb_side_t             s8_side_q;

  always_comb begin
    d2_3    = $unsigned(s2_dxx_q) + $unsigned(s2_dyy_q);
    dot_3   = DOTW'(s2_px_q) + DOTW'(s2_py_q);
    touch_3 = d2_3 <= SQW'(s2_rr_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRONT_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // stage 1: differences and sums
    s1_dx_q   <= $signed({in_i.second_x[VW-1], in_i.second_x})
               - $signed({in_i.first_x[VW-1], in_i.first_x});
    s1_dy_q   <= $signed({in_i.second_y[VW-1], in_i.second_y})
               - $signed({in_i.first_y[VW-1], in_i.first_y});
    s1_dvx_q  <= $signed({in_i.first_vx[VW-1], in_i.first_vx})
               - $signed({in_i.second_vx[VW-1], in_i.second_vx});
    s1_dvy_q  <= $signed({in_i.first_vy[VW-1], in_i.first_vy})
               - $signed({in_i.second_vy[VW-1], in_i.second_vy});
    s1_rs_q   <= {1'b0, in_i.first_radius} + {1'b0, in_i.second_radius};
    s1_msum_q <= {1'b0, in_i.first_mass} + {1'b0, in_i.second_mass};
    s1_m1_q   <= in_i.first_mass;
    s1_m2_q   <= in_i.second_mass;
    s1_mov_q  <= (in_i.first_vx != '0) || (in_i.first_vy != '0) ||
                 (in_i.second_vx != '0) || (in_i.second_vy != '0);
    s1_side_q <= '{v1x: in_i.first_vx, v1y: in_i.first_vy,
                   v2x: in_i.second_vx, v2y: in_i.second_vy,
                   touch: 1'b0, bounce: 1'b0, neg_x: 1'b0, neg_y: 1'b0};

    // stage 2: squares and velocity products
    s2_dxx_q  <= s1_dx_q * s1_dx_q;
    s2_dyy_q  <= s1_dy_q * s1_dy_q;
    s2_px_q   <= s1_dvx_q * s1_dx_q;
    s2_py_q   <= s1_dvy_q * s1_dy_q;
    s2_rr_q   <= s1_rs_q * s1_rs_q;
    s2_adx_q  <= ADW'(s1_dx_q[DXW-1] ? -s1_dx_q : s1_dx_q);
    s2_ady_q  <= ADW'(s1_dy_q[DXW-1] ? -s1_dy_q : s1_dy_q);
    s2_nx_q   <= s1_dx_q[DXW-1];
    s2_ny_q   <= s1_dy_q[DXW-1];
    s2_mov_q  <= s1_mov_q;
    s2_msum_q <= s1_msum_q;
    s2_m1_q   <= s1_m1_q;
    s2_m2_q   <= s1_m2_q;
    s2_side_q <= s1_side_q;

    // stage 3: overlap test, dot product magnitude, term signs
    s3_d2_q   <= d2_3;
    s3_adot_q <= ADOTW'(dot_3[DOTW-1] ? -dot_3 : dot_3);
    s3_adx_q  <= s2_adx_q;
    s3_ady_q  <= s2_ady_q;
    s3_msum_q <= s2_msum_q;
    s3_m1_q   <= s2_m1_q;
    s3_m2_q   <= s2_m2_q;
    s3_side_q <= '{v1x: s2_side_q.v1x, v1y: s2_side_q.v1y,
                   v2x: s2_side_q.v2x, v2y: s2_side_q.v2y,
                   touch: touch_3,
                   bounce: touch_3 && s2_mov_q && (d2_3 != '0) && (s2_msum_q != '0),
                   neg_x: dot_3[DOTW-1] ^ s2_nx_q,
                   neg_y: dot_3[DOTW-1] ^ s2_ny_q};

    // stage 4: split products
    s4_pxl_q  <= s3_adot_q[HW-1:0] * s3_adx_q;
    s4_pxh_q  <= s3_adot_q[ADOTW-1:HW] * s3_adx_q;
    s4_pyl_q  <= s3_adot_q[HW-1:0] * s3_ady_q;
    s4_pyh_q  <= s3_adot_q[ADOTW-1:HW] * s3_ady_q;
    s4_dnl_q  <= s3_msum_q * s3_d2_q[HW-1:0];
    s4_dnh_q  <= s3_msum_q * s3_d2_q[SQW-1:HW];
    s4_m1_q   <= s3_m1_q;
    s4_m2_q   <= s3_m2_q;
    s4_side_q <= s3_side_q;

    // stage 5: recombine
    s5_px_q   <= (PW'(s4_pxh_q) << HW) + PW'(s4_pxl_q);
    s5_py_q   <= (PW'(s4_pyh_q) << HW) + PW'(s4_pyl_q);
    s5_den_q  <= (DENW'(s4_dnh_q) << HW) + DENW'(s4_dnl_q);
    s5_w1_q   <= {s4_m1_q, 1'b0};
    s5_w2_q   <= {s4_m2_q, 1'b0};
    s5_side_q <= s4_side_q;

    // stage 6: weight products, order a1x a1y a2x a2y
    s6_pp_q[0] <= mul3(s5_px_q, s5_w2_q);
    s6_pp_q[1] <= mul3(s5_py_q, s5_w2_q);
    s6_pp_q[2] <= mul3(s5_px_q, s5_w1_q);
    s6_pp_q[3] <= mul3(s5_py_q, s5_w1_q);
    s6_den_q   <= s5_den_q;
    s6_side_q  <= s5_side_q;

    // stage 7: numerators
    for (int t = 0; t < 4; t++) begin
      s7_num_q[t] <= (NUMW'(s6_pp_q[t][2]) << (2 * HW))
                   + (NUMW'(s6_pp_q[t][1]) << HW)
                   + NUMW'(s6_pp_q[t][0]);
    end
    s7_den_q  <= s6_den_q;
    s7_side_q <= s6_side_q;

    // stage 8: round to nearest as floor((2num + den) / 2den)
    for (int t = 0; t < 4; t++) begin
      s8_n_q[t] <= (NW'(s7_num_q[t]) << 1) + NW'(s7_den_q);
    end
    s8_d_q    <= {s7_den_q, 1'b0};
    s8_side_q <= s7_side_q;
  end

  assign valid_o = vld_q[FRONT_STAGES-1];
  assign side_o  = s8_side_q;
  assign num_o   = s8_n_q;
  assign den_o   = s8_d_q;

endmodule

// ===== rtl/ceb_div.sv =====
// ----------------------------------------------------------------------------
// ceb_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ceb_div (
  input  logic                   clk_i,
  input  logic [ceb_pkg::NW-1:0] n_i,
  input  logic [ceb_pkg::DW-1:0] d_i,
  output logic [ceb_pkg::QW-1:0] q_o
);
  import ceb_pkg::*;

  logic [RW-1:0] r_q [QW-1];
  logic [DW-1:0] d_q [QW-1];
  logic [QW-1:0] q_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RW-1:0] r_in;
    logic [RW-1:0] t;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic          ge;

    if (s == 0) begin : g_first
      assign r_in = RW'(n_i);
      assign d_in = d_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_q[s-1];
      assign d_in = d_q[s-1];
      assign q_in = q_q[s-1];
    end

    assign t  = RW'(d_in) << (QW - 1 - s);
    assign ge = r_in >= t;

    always_ff @(posedge clk_i) begin
      q_q[s] <= {q_in[QW-2:0], ge};
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        r_q[s] <= ge ? r_in - t : r_in;
        d_q[s] <= d_in;
      end
    end
  end

  assign q_o = q_q[QW-1];

endmodule

// ===== rtl/ceb_back.sv =====
// ----------------------------------------------------------------------------
// ceb_back
// Applies the signed corrections, doubles the second velocity, saturates.
// ----------------------------------------------------------------------------
module ceb_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  ceb_pkg::ceb_side_t            side_i,
  input  logic [3:0][ceb_pkg::QW-1:0]   q_i,
  output logic                          done_o,
  output ceb_pkg::ceb_out_t             res_o
);
  import ceb_pkg::*;

  logic signed [AW-1:0] a [4];
  logic signed [SW-1:0] raw [4];
  logic [VW-1:0]        sat [4];
  logic [3:0]           clip;
  ceb_out_t             res_d;
  ceb_out_t             res_q;
  logic                 done_q;

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      if ((t == 0 || t == 2) ? side_i.neg_x : side_i.neg_y) begin
        a[t] = -$signed({1'b0, q_i[t]});
      end else begin
        a[t] = $signed({1'b0, q_i[t]});
      end
    end
    raw[0] = SW'(side_i.v1x) - SW'(a[0]);
    raw[1] = SW'(side_i.v1y) - SW'(a[1]);
    raw[2] = (SW'(side_i.v2x) + SW'(a[2])) <<< 1;
    raw[3] = (SW'(side_i.v2y) + SW'(a[3])) <<< 1;
    for (int t = 0; t < 4; t++) begin
      clip[t] = 1'b0;
      sat[t]  = raw[t][VW-1:0];
      if (raw[t] > SW'(V_MAX)) begin
        sat[t]  = V_MAX;
        clip[t] = 1'b1;
      end
      if (raw[t] < SW'(V_MIN)) begin
        sat[t]  = V_MIN;
        clip[t] = 1'b1;
      end
    end

    res_d.touching = side_i.touch;
    res_d.bounced  = side_i.bounce;
    if (side_i.bounce) begin
      res_d.new_first_vx  = sat[0];
      res_d.new_first_vy  = sat[1];
      res_d.new_second_vx = sat[2];
      res_d.new_second_vy = sat[3];
      res_d.clipped       = |clip;
    end else begin
      // pass through, second body not doubled
      res_d.new_first_vx  = side_i.v1x;
      res_d.new_first_vy  = side_i.v1y;
      res_d.new_second_vx = side_i.v2x;
      res_d.new_second_vy = side_i.v2y;
      res_d.clipped       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/circle_elastic_bounce.sv =====
// ----------------------------------------------------------------------------
// circle_elastic_bounce
// Overlap test and elastic velocity exchange for a pair of circular bodies.
// ----------------------------------------------------------------------------
// The block takes one body pair in every cycle and returns each result as a
// single-cycle done_o pulse; busy never rises and there is no back pressure,
// so the receiver must capture each result when it appears.
// A result passes through eight setup stages (differences, products, overlap test,
// dividends), 27 stages of the bit-per-stage divider that forms the four
// rounded correction terms, and one output stage for sign, doubling and
// saturation.
module circle_elastic_bounce (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ceb_pkg::ceb_in_t  in_i,
  output logic              done_o,
  output ceb_pkg::ceb_out_t res_o
);
  import ceb_pkg::*;

  logic               f_valid;
  ceb_side_t          f_side;
  logic [3:0][NW-1:0] f_num;
  logic [DW-1:0]      f_den;
  logic [3:0][QW-1:0] quo;
  ceb_side_t          side_q [QW];
  logic [QW-1:0]      vld_q;

  assign busy = 1'b0;

  ceb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .in_i    (in_i),
    .valid_o (f_valid),
    .side_o  (f_side),
    .num_o   (f_num),
    .den_o   (f_den)
  );

  for (genvar t = 0; t < 4; t++) begin : g_div
    ceb_div u_div (
      .clk_i (clk_i),
      .n_i   (f_num[t]),
      .d_i   (f_den),
      .q_o   (quo[t])
    );
  end

  // hold side data alongside the divider stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-2:0], f_valid};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= f_side;
    for (int s = 1; s < QW; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  ceb_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[QW-1]),
    .side_i  (side_q[QW-1]),
    .q_i     (quo),
    .done_o  (done_o),
    .res_o   (res_o)
  );

endmodule

// ===== rtl/ceb_chk.sv =====
// ----------------------------------------------------------------------------
// ceb_chk
// Port-level checks on result timing and pass-through behavior.
// ----------------------------------------------------------------------------
module ceb_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input ceb_pkg::ceb_in_t  in_i,
  input logic              done_o,
  input ceb_pkg::ceb_out_t res_o
);
  import ceb_pkg::*;

  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result without an accepted transaction");

  a_bounce_needs_touch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.touching) |-> !res_o.bounced)
    else $error("bounce reported without contact");

  a_pass_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.bounced) |->
      (!res_o.clipped && res_o.new_first_vx == $past(in_i.first_vx, LAT)))
    else $error("first velocity not passed through");

  a_pass_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !res_o.bounced) |-> (res_o.new_second_vy == $past(in_i.second_vy, LAT)))
    else $error("second velocity not passed through");

endmodule

bind circle_elastic_bounce ceb_chk u_ceb_chk (.*);
